// ----- rtl/ist_pkg.sv -----
// Shared constants for the increasing subsequence tracker.
// Used by the search cell and the top level; depends on nothing.
`timescale 1ns / 1ps

package ist_pkg;

    // Width of one sequence element.
    localparam int VALUE_W = 32;

    // Default table depth and item index width.
    localparam int DEF_MAX_LENGTH = 1024;
    localparam int DEF_INDEX_BITS = 16;

endpackage

// ----- rtl/ist_cell.sv -----
// One search cell of the tail table: it owns the tails whose position has exactly
// LEVEL trailing ones and makes one binary-search decision per item. Depends on ist_pkg.
`timescale 1ns / 1ps

module ist_cell
    import ist_pkg::*;
#(
    parameter int LEVEL      = 0,
    parameter int MAX_LENGTH = DEF_MAX_LENGTH,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [$clog2(MAX_LENGTH+1)-1:0]   i_len,
    input  logic                              i_tok_valid,
    input  logic [$clog2(MAX_LENGTH+1)-1:0]   i_tok_pos,
    input  logic signed [VALUE_W-1:0]         i_tok_value,
    input  logic [INDEX_BITS:0]               i_tok_pred,
    output logic                              o_tok_valid,
    output logic [$clog2(MAX_LENGTH+1)-1:0]   o_tok_pos,
    output logic signed [VALUE_W-1:0]         o_tok_value,
    output logic [INDEX_BITS:0]               o_tok_pred,
    input  logic                              i_wr_en,
    input  logic [$clog2(MAX_LENGTH+1)-1:0]   i_wr_pos,
    input  logic signed [VALUE_W-1:0]         i_wr_value,
    input  logic [INDEX_BITS-1:0]             i_wr_index
);

    localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
    localparam int STEP   = 1 << LEVEL;
    localparam int DEPTH  = (MAX_LENGTH - STEP) / (2 * STEP) + 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [LEN_W-1:0] SEL_MASK  = LEN_W'((2 * STEP) - 1);
    localparam logic [LEN_W-1:0] SEL_MATCH = LEN_W'(STEP - 1);

    // Tail values and their item indexes held by this cell.
    logic signed [VALUE_W-1:0] mem_value [DEPTH];
    logic [INDEX_BITS-1:0]     mem_index [DEPTH];

    logic                      r_valid;
    logic [LEN_W-1:0]          r_pos;
    logic signed [VALUE_W-1:0] r_value;
    logic [INDEX_BITS:0]       r_pred;
    logic signed [VALUE_W-1:0] r_rd_value;
    logic [INDEX_BITS-1:0]     r_rd_index;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_hit;
    logic              fits;
    logic              take;

    // The tail probed is position pos + STEP - 1; its entry in this cell is pos >> (LEVEL+1).
    assign rd_addr = ADDR_W'(i_tok_pos >> (LEVEL + 1));
    assign wr_addr = ADDR_W'(i_wr_pos >> (LEVEL + 1));
    assign wr_hit  = i_wr_en && ((i_wr_pos & SEL_MASK) == SEL_MATCH);

    // Table write for the item that just finished.
    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            mem_value[wr_addr] <= i_wr_value;
            mem_index[wr_addr] <= i_wr_index;
        end
    end

    // Read of the probed tail; a write to the same entry in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_tok_valid) begin
            if (wr_hit && (wr_addr == rd_addr)) begin
                r_rd_value <= i_wr_value;
                r_rd_index <= i_wr_index;
            end else begin
                r_rd_value <= mem_value[rd_addr];
                r_rd_index <= mem_index[rd_addr];
            end
            r_pos   <= i_tok_pos;
            r_value <= i_tok_value;
            r_pred  <= i_tok_pred;
        end
    end

    // The search item is registered in this cell; its valid flag is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_tok_valid;
        end
    end

    // Step forward when the probed tail exists and is less than the value.
    assign fits = ({1'b0, r_pos} + (LEN_W + 1)'(STEP)) <= {1'b0, i_len};
    assign take = r_valid && fits && (r_rd_value < r_value);

    assign o_tok_valid = r_valid;
    assign o_tok_pos   = take ? (r_pos + LEN_W'(STEP)) : r_pos;
    assign o_tok_value = r_value;
    assign o_tok_pred  = take ? {1'b0, r_rd_index} : r_pred;

endmodule

// ----- rtl/increasing_subsequence_tracker.sv -----
// Top level of the increasing subsequence tracker: input and result channels,
// length and index bookkeeping, and the chain of ist_cell search cells. Depends on ist_pkg.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready) carries one item: a signed 32-bit value and
//   a start flag that clears the table length and the item counter before that item.
// - Result channel (o_out_valid / i_out_ready) returns one item per input: the slot
//   written, the longest length so far, the predecessor item index (all ones for none),
//   the item's own index and an overflow flag for an extension dropped on a full table.
// - The search runs through L = $clog2(MAX_LENGTH+1) cells, one cell per cycle, each
//   cell holding the tails of one level of the binary search in its own memory.
// - A result passes the cell registers, the finish registers and the result register.
// - One item is searched at a time: the next item is taken once the last one has passed
//   the whole cell chain, in the cycle that writes its table entry.
// - Reset clears length, item counter and handshake state; table contents stay as
//   they are and are never used before being written again.
// - If the receiver stalls, the result waits in the output register. The next item is
//   still taken and searched, then holds in the last stage with the input blocked until
//   the waiting result has been handed over.
`timescale 1ns / 1ps

module increasing_subsequence_tracker
    import ist_pkg::*;
#(
    parameter int MAX_LENGTH = DEF_MAX_LENGTH,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [VALUE_W-1:0]         i_value,
    input  logic                              i_start_req,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [$clog2(MAX_LENGTH+1)-1:0]   o_slot,
    output logic [$clog2(MAX_LENGTH+1)-1:0]   o_run_length,
    output logic signed [INDEX_BITS:0]        o_predecessor,
    output logic [INDEX_BITS-1:0]             o_item_index,
    output logic                              o_overflow
);

    localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
    localparam int LEVELS = LEN_W;
    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_LENGTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [LEN_W-1:0]          r_len;
    logic [INDEX_BITS-1:0]     r_next_idx;
    logic [INDEX_BITS-1:0]     r_cur_idx;
    logic signed [VALUE_W-1:0] r_value;
    logic [LEN_W-1:0]          r_fin_pos;
    logic [INDEX_BITS:0]       r_fin_pred;

    logic                      r_out_valid;
    logic [LEN_W-1:0]          r_slot;
    logic [LEN_W-1:0]          r_run_length;
    logic [INDEX_BITS:0]       r_pred;
    logic [INDEX_BITS-1:0]     r_item_index;
    logic                      r_overflow;

    logic                      in_accept;
    logic                      fin_fire;
    logic                      fin_ovf;
    logic [LEN_W-1:0]          new_len;
    logic [LEN_W-1:0]          len_after;
    logic [INDEX_BITS-1:0]     cur_idx;
    logic                      wr_en;

    logic [LEVELS:0]           tok_valid;
    logic [LEN_W-1:0]          tok_pos   [LEVELS+1];
    logic signed [VALUE_W-1:0] tok_value [LEVELS+1];
    logic [INDEX_BITS:0]       tok_pred  [LEVELS+1];

    // Handshake: a finished item hands over while the next one is taken.
    assign fin_fire   = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == ST_IDLE) || fin_fire;
    assign in_accept  = i_in_valid && o_in_ready;

    // Outcome of the finished search.
    assign fin_ovf   = (r_fin_pos == FULL_LEN);
    assign new_len   = (!fin_ovf && (r_fin_pos == r_len)) ? (r_len + LEN_W'(1)) : r_len;
    assign len_after = fin_fire ? new_len : r_len;
    assign cur_idx   = i_start_req ? '0 : r_next_idx;
    assign wr_en     = fin_fire && !fin_ovf;

    // A new item enters the first cell at position zero with no predecessor.
    assign tok_valid[0] = in_accept;
    assign tok_pos[0]   = '0;
    assign tok_value[0] = i_value;
    assign tok_pred[0]  = '1;

    // Chain of search cells, from the widest step down to a step of one.
    for (genvar k = 0; k < LEVELS; k++) begin : g_cell
        ist_cell #(
            .LEVEL      (LEVELS - 1 - k),
            .MAX_LENGTH (MAX_LENGTH),
            .INDEX_BITS (INDEX_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_len       (r_len),
            .i_tok_valid (tok_valid[k]),
            .i_tok_pos   (tok_pos[k]),
            .i_tok_value (tok_value[k]),
            .i_tok_pred  (tok_pred[k]),
            .o_tok_valid (tok_valid[k+1]),
            .o_tok_pos   (tok_pos[k+1]),
            .o_tok_value (tok_value[k+1]),
            .o_tok_pred  (tok_pred[k+1]),
            .i_wr_en     (wr_en),
            .i_wr_pos    (r_fin_pos),
            .i_wr_value  (r_value),
            .i_wr_index  (r_cur_idx)
        );
    end

    // Sequencer state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (tok_valid[LEVELS]) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (in_accept) n_state = ST_SEARCH;
                else if (fin_fire) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers: state, table length, item counter, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_next_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_len      <= i_start_req ? '0 : len_after;
                r_next_idx <= cur_idx + INDEX_BITS'(1);
            end else if (fin_fire) begin
                r_len <= new_len;
            end
            if (fin_fire) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Item payload and search outcome held for the table write and the result.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_value   <= i_value;
            r_cur_idx <= cur_idx;
        end
        if (tok_valid[LEVELS]) begin
            r_fin_pos  <= tok_pos[LEVELS];
            r_fin_pred <= tok_pred[LEVELS];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (fin_fire) begin
            r_slot       <= fin_ovf ? '0 : (r_fin_pos + LEN_W'(1));
            r_run_length <= new_len;
            r_pred       <= fin_ovf ? '1 : r_fin_pred;
            r_item_index <= r_cur_idx;
            r_overflow   <= fin_ovf;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot        = r_slot;
    assign o_run_length  = r_run_length;
    assign o_predecessor = r_pred;
    assign o_item_index  = r_item_index;
    assign o_overflow    = r_overflow;

`ifndef SYNTHESIS
    // Only one item travels through the cell chain at a time.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(tok_valid) <= 1)
        else $error("more than one item in the cell chain");

    // The chain finishes an item only while the sequencer is searching.
    a_finish_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_valid[LEVELS] |-> r_state == ST_SEARCH)
        else $error("search result outside the search state");

    // A dropped extension reports slot zero, no predecessor and a full table.
    a_overflow_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |->
            (o_slot == '0) && (o_predecessor == '1) && (o_run_length == FULL_LEN))
        else $error("inconsistent overflow result");

    // A written slot lies within the current longest length.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_overflow) |-> (o_slot != '0) && (o_slot <= o_run_length))
        else $error("slot outside the table length");
`endif

endmodule

// ----- tb/increasing_subsequence_tracker_tb.sv -----
// Self-checking testbench for the increasing subsequence tracker.
// Predicts every result from a copy of the tail table; depends on ist_pkg and the tracker RTL.
`timescale 1ns / 1ps

module increasing_subsequence_tracker_tb;
    import ist_pkg::*;

    localparam int MAX_LEN = DEF_MAX_LENGTH;
    localparam int IDX_W = DEF_INDEX_BITS;
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int LATENCY = LEN_W + 1;
    localparam int CYCLE_LIMIT = 400_000;
    localparam longint VALUE_MIN = -(longint'(1) << (VALUE_W - 1));
    localparam longint VALUE_MAX = (longint'(1) << (VALUE_W - 1)) - 1;
    localparam logic signed [IDX_W:0] NO_PREDECESSOR = -1;

    typedef enum {SHAPE_RISING, SHAPE_FALLING, SHAPE_NARROW, SHAPE_SPREAD, SHAPE_EXTREME} t_run_shape;

    // One result item as it leaves the block.
    typedef struct {
        logic [LEN_W-1:0]        slot;
        logic [LEN_W-1:0]        run_length;
        logic signed [IDX_W:0]   predecessor;
        logic [IDX_W-1:0]        item_index;
        logic                    overflow;
    } t_lis_result;

    // Mirror of the tail table plus the results still owed by the block.
    class t_lis_tail_table;
        logic signed [VALUE_W-1:0] tails [MAX_LEN];
        logic [IDX_W-1:0]          tail_item [MAX_LEN];
        int                        run_len;
        logic [IDX_W-1:0]          next_item;
        t_lis_result               awaited_results[$];
        int                        mismatches;
        int                        values_taken;
        int                        results_seen;
        int                        overflows;
        int                        index_wraps;

        function new();
            run_len = 0;
            next_item = '0;
            mismatches = 0;
            values_taken = 0;
            results_seen = 0;
            overflows = 0;
            index_wraps = 0;
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40) begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endtask

        // Apply one accepted item to the table and queue the result it must produce.
        function void absorb_value(logic signed [VALUE_W-1:0] value, logic start);
            t_lis_result r;
            int lo;
            int hi;
            int mid;
            if (start) begin
                run_len = 0;
                next_item = '0;
            end
            r.item_index = next_item;
            next_item = next_item + 1'b1;
            if (next_item == '0) begin
                index_wraps++;
            end
            values_taken++;

            // Find the first tail that is not less than the value.
            lo = 0;
            hi = run_len;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (tails[mid] < value) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end

            r.predecessor = NO_PREDECESSOR;
            r.overflow = 1'b0;
            r.slot = '0;
            if (lo >= MAX_LEN) begin
                // Extension of a full table is dropped.
                r.overflow = 1'b1;
                overflows++;
            end else begin
                if (lo > 0) begin
                    r.predecessor = {1'b0, tail_item[lo-1]};
                end
                tails[lo] = value;
                tail_item[lo] = r.item_index;
                if (lo == run_len) begin
                    run_len++;
                end
                r.slot = LEN_W'(lo + 1);
            end
            r.run_length = LEN_W'(run_len);
            awaited_results.push_back(r);
        endfunction

        // Compare one delivered result against the oldest queued one.
        task check_result(t_lis_result seen);
            t_lis_result want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("result with no item pending, item_index %0d",
                                        seen.item_index));
                return;
            end
            want = awaited_results.pop_front();
            if (seen.slot !== want.slot)
                flag_mismatch($sformatf("item %0d slot %0d, expected %0d",
                                        want.item_index, seen.slot, want.slot));
            if (seen.run_length !== want.run_length)
                flag_mismatch($sformatf("item %0d run_length %0d, expected %0d",
                                        want.item_index, seen.run_length, want.run_length));
            if (seen.predecessor !== want.predecessor)
                flag_mismatch($sformatf("item %0d predecessor %0d, expected %0d",
                                        want.item_index, seen.predecessor, want.predecessor));
            if (seen.item_index !== want.item_index)
                flag_mismatch($sformatf("item_index %0d, expected %0d",
                                        seen.item_index, want.item_index));
            if (seen.overflow !== want.overflow)
                flag_mismatch($sformatf("item %0d overflow %0b, expected %0b",
                                        want.item_index, seen.overflow, want.overflow));
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [VALUE_W-1:0]  i_value = '0;
    logic                       i_start_req = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [LEN_W-1:0]           o_slot;
    logic [LEN_W-1:0]           o_run_length;
    logic signed [IDX_W:0]      o_predecessor;
    logic [IDX_W-1:0]           o_item_index;
    logic                       o_overflow;

    t_lis_tail_table lis_table;
    int              idle_pct = 0;
    int              stall_left = 0;
    int              cycles = 0;

    increasing_subsequence_tracker #(
        .MAX_LENGTH(MAX_LEN),
        .INDEX_BITS(IDX_W)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_value(i_value),
        .i_start_req(i_start_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_slot(o_slot),
        .o_run_length(o_run_length),
        .o_predecessor(o_predecessor),
        .o_item_index(o_item_index),
        .o_overflow(o_overflow)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending.", cycles,
                     lis_table.awaited_results.size());
            $display("increasing_subsequence_tracker_tb: FAIL");
            $finish;
        end
    end

    // Result receiver: stalls come in short random bursts while idling is enabled.
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(1, 7) - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Every handed-over result is checked at the edge that accepts it.
    always @(posedge i_clk) begin
        t_lis_result seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.slot = o_slot;
            seen.run_length = o_run_length;
            seen.predecessor = o_predecessor;
            seen.item_index = o_item_index;
            seen.overflow = o_overflow;
            lis_table.check_result(seen);
        end
    end

    // Offer one item, wait for its acceptance, and return at the next falling edge.
    task automatic feed_value(input logic signed [VALUE_W-1:0] value, input logic start);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value <= value;
        i_start_req <= start;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        lis_table.absorb_value(value, start);
        @(negedge i_clk);
    endtask

    // A run of values with a chosen shape; the walk carries the trend between items.
    task automatic feed_run(input int count, input t_run_shape shape, input bit lead_start,
                            input bit noise_starts);
        longint walk;
        logic   start;
        walk = longint'($signed($urandom()));
        for (int k = 0; k < count; k++) begin
            case (shape)
                SHAPE_RISING:  walk = walk + int'($urandom_range(0, 4000)) - 1000;
                SHAPE_FALLING: walk = walk - int'($urandom_range(0, 4000)) + 1000;
                SHAPE_NARROW:  walk = longint'($urandom_range(0, 7)) - 4;
                SHAPE_EXTREME: begin
                    case ($urandom_range(0, 4))
                        0: walk = VALUE_MIN;
                        1: walk = VALUE_MAX;
                        2: walk = 0;
                        3: walk = -1;
                        default: walk = longint'($signed($urandom()));
                    endcase
                end
                default: walk = longint'($signed($urandom()));
            endcase
            start = (k == 0 && lead_start) || (noise_starts && $urandom_range(0, 29) == 0);
            feed_value(walk[VALUE_W-1:0], start);
        end
    endtask

    // Grow the table to its full depth, then push items past it, some of which must overflow.
    task automatic fill_table();
        longint top;
        longint v;
        top = VALUE_MIN + $urandom_range(0, 1000);
        feed_value(top[VALUE_W-1:0], 1'b1);
        while (lis_table.run_len < MAX_LEN) begin
            if ($urandom_range(0, 15) == 0) begin
                v = top - $urandom_range(0, 100000);
                if (v < VALUE_MIN) begin
                    v = top;
                end
            end else begin
                top = top + $urandom_range(1, 2000000);
                v = top;
            end
            feed_value(v[VALUE_W-1:0], 1'b0);
        end
        // With the table full, larger values are dropped and smaller ones still replace.
        for (int k = 0; k < 16; k++) begin
            case ($urandom_range(0, 2))
                0: v = VALUE_MAX;
                1: v = top + $urandom_range(1, 1000);
                default: v = top - $urandom_range(0, 100000);
            endcase
            feed_value(v[VALUE_W-1:0], 1'b0);
        end
    endtask

    // Random runs of mixed shape and idling until the item count reaches the target.
    task automatic feed_random_runs(input int target);
        while (lis_table.values_taken < target) begin
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 35;
            endcase
            feed_run($urandom_range(1, 40), t_run_shape'($urandom_range(0, 4)),
                     $urandom_range(0, 4) != 0, 1'b1);
        end
    endtask

    initial begin
        int final_target;
        lis_table = new();

        // Synchronous reset, released at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items: extremes, equal values, first slot, restarts.
        idle_pct = 20;
        feed_value(0, 1'b1);
        feed_value(VALUE_MAX[VALUE_W-1:0], 1'b0);
        feed_value(VALUE_MAX[VALUE_W-1:0], 1'b0);
        feed_value(VALUE_MIN[VALUE_W-1:0], 1'b0);
        feed_value(-1, 1'b0);
        feed_value(5, 1'b0);
        feed_value(5, 1'b0);
        feed_value(3, 1'b0);
        feed_value(4, 1'b0);
        feed_value(32'h5555_5555, 1'b0);
        feed_value(32'hAAAA_AAAA, 1'b0);
        feed_value(100, 1'b1);
        feed_value(50, 1'b0);
        feed_value(50, 1'b0);
        feed_value(-100, 1'b0);
        feed_value(VALUE_MIN[VALUE_W-1:0], 1'b1);
        feed_value(VALUE_MIN[VALUE_W-1:0], 1'b1);
        feed_value(VALUE_MIN[VALUE_W-1:0], 1'b0);
        feed_value(VALUE_MAX[VALUE_W-1:0], 1'b0);
        feed_value(VALUE_MAX[VALUE_W-1:0], 1'b1);

        // Random runs, then one full-table pass.
        feed_random_runs(60);
        idle_pct = 10;
        fill_table();

        // Last part without idling: mixed runs with restarts.
        idle_pct = 0;
        final_target = lis_table.values_taken + 60;
        while (lis_table.values_taken < final_target) begin
            feed_run($urandom_range(1, 40), t_run_shape'($urandom_range(0, 4)),
                     $urandom_range(0, 4) != 0, 1'b1);
        end
        i_in_valid <= 1'b0;

        // Drain, then allow extra cycles for anything unexpected.
        while (lis_table.awaited_results.size() != 0) @(posedge i_clk);
        repeat (4 * LATENCY) @(posedge i_clk);
        if (lis_table.awaited_results.size() != 0) begin
            lis_table.flag_mismatch($sformatf("%0d results never arrived",
                                              lis_table.awaited_results.size()));
        end

        $display("Fed %0d values (directed, random runs, one full table), checked %0d results.",
                 lis_table.values_taken, lis_table.results_seen);
        $display("Saw %0d dropped extensions and %0d item index wraps; %0d mismatches.",
                 lis_table.overflows, lis_table.index_wraps, lis_table.mismatches);
        if (lis_table.mismatches == 0) begin
            $display("increasing_subsequence_tracker_tb: PASS");
        end else begin
            $display("increasing_subsequence_tracker_tb: FAIL");
        end
        $finish;
    end

endmodule
